>>> rtl/core/fld_pkg.sv
`timescale 1ns / 1ps

package fld_pkg;

   localparam int WORDS_DEFAULT = 3;

   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 2 * BYTE_W;
   localparam int INDEX_W = 2;

   localparam int          CSR_INDEX_W = 2;
   localparam int          CSR_DATA_W  = BYTE_W;
   localparam logic [1:0]  CSR_HEADER  = 2'd0;
   localparam logic [1:0]  CSR_TRAILER = 2'd1;

   localparam logic [7:0]  HEADER_RESET  = 8'hFF;
   localparam logic [7:0]  TRAILER_RESET = 8'hFE;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_COLLECT = 2'd1,
      PH_TRAILER = 2'd2
   } phase_type;

   // control shared by every cell of the output word row
   typedef struct packed {
      logic load;   // take a new frame from the byte row
      logic shift;  // head word was taken, move up by one
   } word_ctrl_type;

endpackage

>>> rtl/core/fld_byte_cell.sv
`timescale 1ns / 1ps

module fld_byte_cell (
   input  logic                        clock,
   input  logic                        shift_en,
   input  logic [fld_pkg::BYTE_W-1:0]  byte_in,
   output logic [fld_pkg::BYTE_W-1:0]  byte_out
);

   logic [fld_pkg::BYTE_W-1:0] byte_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

>>> rtl/core/fld_word_cell.sv
`timescale 1ns / 1ps

module fld_word_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  fld_pkg::word_ctrl_type      ctrl,
   input  logic [fld_pkg::BYTE_W-1:0]  lo_byte,
   input  logic [fld_pkg::BYTE_W-1:0]  hi_byte,
   input  logic                        next_valid,
   input  logic [fld_pkg::WORD_W-1:0]  next_value,
   output logic                        valid,
   output logic [fld_pkg::WORD_W-1:0]  value
);

   logic                       valid_ff;
   logic [fld_pkg::WORD_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.load) begin
         valid_ff <= 1'b1;
      end else if (ctrl.shift) begin
         valid_ff <= next_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         value_ff <= {hi_byte, lo_byte};
      end else if (ctrl.shift) begin
         value_ff <= next_value;
      end
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

>>> rtl/core/fixed_length_frame_deframer_unit.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------------------
// req_      | in        | req_valid/req_stall  | req_rx_byte[7:0]
// rsp_      | out       | rsp_valid/rsp_stall  | rsp_word_index[1:0], rsp_word_value[15:0],
//           |           |                      | rsp_last_word
// csr_      | in        | csr_valid/csr_ready  | csr_index[1:0], csr_wdata[7:0]
//
// One request per cycle. Only a request in the trailer phase can be held
// off: req_stall rises in the trailer phase while the output word row still
// holds words of the previous frame. Words of a frame leave one per cycle from
// the cycle after the trailer while rsp_stall stays low.
// Synchronous active-high reset: hunt phase, empty word row, registers to
// header 0xFF and trailer 0xFE. Payload bytes are not reset.

module fixed_length_frame_deframer_unit #(
   parameter int WORDS = fld_pkg::WORDS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [fld_pkg::BYTE_W-1:0]       req_rx_byte,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [fld_pkg::INDEX_W-1:0]      rsp_word_index,
   output logic [fld_pkg::WORD_W-1:0]       rsp_word_value,
   output logic                             rsp_last_word,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fld_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fld_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int NBYTES = 2 * WORDS;
   localparam int CNT_W  = $clog2(NBYTES);
   localparam int IDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

   // ---------------------------------------------------------------
   // configuration registers; always ready
   // ---------------------------------------------------------------
   logic [fld_pkg::BYTE_W-1:0] header_ff;
   logic [fld_pkg::BYTE_W-1:0] trailer_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= fld_pkg::HEADER_RESET;
         trailer_ff <= fld_pkg::TRAILER_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            fld_pkg::CSR_HEADER:  header_ff  <= csr_wdata;
            fld_pkg::CSR_TRAILER: trailer_ff <= csr_wdata;
            default: ;  // unknown index: dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // phase FSM and byte counter
   // ---------------------------------------------------------------
   fld_pkg::phase_type     phase_ff, phase_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   req_take;
   logic                   rsp_take;
   logic                   collect_shift;
   fld_pkg::word_ctrl_type wctrl;

   logic                       wvalid [WORDS];
   logic [fld_pkg::WORD_W-1:0] wvalue [WORDS];

   // a trailer may only load the word row once it has drained
   assign req_stall = (phase_ff == fld_pkg::PH_TRAILER) && wvalid[0];
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= fld_pkg::PH_HUNT;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      collect_shift = 1'b0;
      wctrl.load    = 1'b0;
      wctrl.shift   = rsp_take;
      case (phase_ff)
         fld_pkg::PH_HUNT: begin
            if (req_take && (req_rx_byte == header_ff)) begin
               phase_in = fld_pkg::PH_COLLECT;
            end
         end
         fld_pkg::PH_COLLECT: begin
            // every byte is payload here, header and trailer values included
            if (req_take) begin
               collect_shift = 1'b1;
               if (cnt_ff == CNT_W'(NBYTES - 1)) begin
                  cnt_in   = '0;
                  phase_in = fld_pkg::PH_TRAILER;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         fld_pkg::PH_TRAILER: begin
            // non-trailer bytes are dropped
            if (req_take && (req_rx_byte == trailer_ff)) begin
               wctrl.load = 1'b1;
               phase_in   = fld_pkg::PH_HUNT;
            end
         end
         default: begin
            if (req_take) begin
               phase_in = fld_pkg::PH_HUNT;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------
   // byte row: new byte enters at the top cell and walks down, so the
   // first payload byte ends up in cell 0
   // ---------------------------------------------------------------
   logic [fld_pkg::BYTE_W-1:0] pbyte [NBYTES];

   for (genvar k = 0; k < NBYTES; k++) begin : g_byte
      logic [fld_pkg::BYTE_W-1:0] feed;
      if (k == NBYTES - 1) begin : g_top
         assign feed = req_rx_byte;
      end else begin : g_mid
         assign feed = pbyte[k+1];
      end
      fld_byte_cell u_cell (
         .clock    (clock),
         .shift_en (collect_shift),
         .byte_in  (feed),
         .byte_out (pbyte[k])
      );
   end

   // ---------------------------------------------------------------
   // word row: loaded in parallel on trailer, drains from cell 0
   // ---------------------------------------------------------------
   for (genvar w = 0; w < WORDS; w++) begin : g_word
      logic                       nvalid;
      logic [fld_pkg::WORD_W-1:0] nvalue;
      if (w == WORDS - 1) begin : g_end
         assign nvalid = 1'b0;
         assign nvalue = '0;
      end else begin : g_mid
         assign nvalid = wvalid[w+1];
         assign nvalue = wvalue[w+1];
      end
      fld_word_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (wctrl),
         .lo_byte    (pbyte[2*w]),
         .hi_byte    (pbyte[2*w+1]),
         .next_valid (nvalid),
         .next_value (nvalue),
         .valid      (wvalid[w]),
         .value      (wvalue[w])
      );
   end

   // position of the head word within its frame
   logic [IDX_W-1:0] idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (wctrl.load) begin
         idx_ff <= '0;
      end else if (rsp_take) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   assign rsp_valid      = wvalid[0];
   assign rsp_word_value = wvalue[0];
   assign rsp_word_index = fld_pkg::INDEX_W'(idx_ff);
   assign rsp_last_word  = (idx_ff == IDX_W'(WORDS - 1));

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      wctrl.load |-> !wvalid[0])
      else $error("word row loaded while still holding words");

   a_trailer_emits: assert property (@(posedge clock) disable iff (reset)
      wctrl.load |=> rsp_valid && (idx_ff == '0))
      else $error("trailer did not start a new word burst");

   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != fld_pkg::PH_COLLECT) |-> (cnt_ff == '0))
      else $error("byte counter nonzero outside collect phase");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last_word) |=> !rsp_valid)
      else $error("words left after last word of frame");

endmodule
